FILE: hdl/udec_pkg.sv
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types and character codes for the URL percent decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_t;

  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic                      last;
  } res_t;

endpackage

FILE: hdl/udec_decode.sv
// ----------------------------------------------------------------------------
// udec_decode
// Combinational decode of one input byte against the held escape state.
// ----------------------------------------------------------------------------
module udec_decode (
  input  udec_pkg::pend_t pend,
  input  logic [7:0]      first_digit,
  input  logic [7:0]      cur_byte,
  input  logic            cur_last,
  output udec_pkg::pend_t pend_nxt,
  output logic [7:0]      first_digit_nxt,
  output udec_pkg::res_t  res
);

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    hex_val = c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic logic is_safe(input logic [7:0] v);
    is_safe = (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5A) ||
              (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h26 && v <= 8'h2F) ||
              v == 8'h21 || v == 8'h24 || v == 8'h3A || v == 8'h3B ||
              v == 8'h3D || v == 8'h3F || v == 8'h40 || v == 8'h5F;
  endfunction

  function automatic udec_pkg::res_t push(input udec_pkg::res_t r, input logic [7:0] b);
    udec_pkg::res_t o;
    o = r;
    if (r.cnt != 2'd3) begin
      o.bytes[r.cnt] = b;
      o.cnt          = r.cnt + 2'd1;
    end
    return o;
  endfunction

  logic       cur_hex;
  logic [7:0] dec_val;

  assign cur_hex = is_hex(cur_byte);
  assign dec_val = {hex_val(first_digit), hex_val(cur_byte)};

  always_comb begin
    udec_pkg::res_t r;
    udec_pkg::pend_t p;
    logic [7:0] fd;
    logic do_plain;
    r        = '0;
    p        = udec_pkg::PEND_NONE;
    fd       = first_digit;
    do_plain = 1'b0;
    unique case (pend)
      udec_pkg::PEND_PCT: begin
        if (cur_hex) begin
          p  = udec_pkg::PEND_DIGIT;
          fd = cur_byte;
        end else begin
          r        = push(r, udec_pkg::CH_PCT);
          do_plain = 1'b1;
        end
      end
      udec_pkg::PEND_DIGIT: begin
        if (cur_hex) begin
          if (!is_safe(dec_val)) begin
            r = push(r, dec_val);
          end else begin
            r = push(r, udec_pkg::CH_PCT);
            r = push(r, first_digit);
            r = push(r, cur_byte);
          end
        end else begin
          r        = push(r, udec_pkg::CH_PCT);
          r        = push(r, first_digit);
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
    if (do_plain) begin
      priority if (cur_byte == udec_pkg::CH_PLUS) begin
        r = push(r, udec_pkg::CH_SPACE);
      end else if (cur_byte == udec_pkg::CH_PCT) begin
        p = udec_pkg::PEND_PCT;
      end else begin
        r = push(r, cur_byte);
      end
    end
    if (cur_last) begin
      if (p != udec_pkg::PEND_NONE) begin
        r = push(r, udec_pkg::CH_PCT);
      end
      if (p == udec_pkg::PEND_DIGIT) begin
        r = push(r, fd);
      end
      p  = udec_pkg::PEND_NONE;
      fd = 8'h00;
    end
    r.last          = cur_last;
    res             = r;
    pend_nxt        = p;
    first_digit_nxt = fd;
  end

endmodule

FILE: hdl/udec_outbuf.sv
// ----------------------------------------------------------------------------
// udec_outbuf
// Result register that holds up to three decoded bytes and sends them out
// one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module udec_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  udec_pkg::res_t res,
  output logic           load_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic [udec_pkg::MAX_RES-1:0][7:0] data_r;
  logic [1:0]                        rem_r;
  logic [1:0]                        rem_nxt;
  logic                              last_r;
  logic                              pop;

  assign out_valid = (rem_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign load_ok   = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_ready);
  assign out_byte  = data_r[0];
  assign out_last  = last_r && (rem_r == 2'd1);

  always_comb begin
    priority if (load) begin
      rem_nxt = res.cnt;
    end else if (pop) begin
      rem_nxt = rem_r - 2'd1;
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res.bytes;
      last_r <= res.last;
    end else if (pop) begin
      data_r <= {8'h00, data_r[udec_pkg::MAX_RES-1:1]};
    end
  end

endmodule

FILE: hdl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent-escape decoder with valid/ready channels.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle into an input register while in_ready
// is high; the decoder turns it combinationally into zero to three result
// bytes and loads them into a result register that drives the output port
// one byte per cycle while out_ready is high. The sustained rate is one byte
// per cycle while each byte yields at most one result and out_ready stays
// high; a byte with several results holds the output port until all are out,
// and that single-byte port sets the rate; bytes pass both registers in turn.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;
  udec_pkg::pend_t pend_r;
  udec_pkg::pend_t pend_nxt;
  logic [7:0]      fd_r;
  logic [7:0]      fd_nxt;
  udec_pkg::res_t  res;
  logic            load_ok;
  logic            dec_go;
  logic            in_acc;

  assign dec_go   = s1_valid_r && load_ok;
  assign in_ready = !s1_valid_r || load_ok;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    priority if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (dec_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_r     <= udec_pkg::PEND_NONE;
      fd_r       <= 8'h00;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (dec_go) begin
        pend_r <= pend_nxt;
        fd_r   <= fd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  udec_decode u_decode (
    .pend            (pend_r),
    .first_digit     (fd_r),
    .cur_byte        (s1_byte_r),
    .cur_last        (s1_last_r),
    .pend_nxt        (pend_nxt),
    .first_digit_nxt (fd_nxt),
    .res             (res)
  );

  udec_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (dec_go),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: hdl/udec_checker.sv
// ----------------------------------------------------------------------------
// udec_checker
// Port-level checks for the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module udec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // A stalled request must hold its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // With no result waiting and no new request, the held byte drains.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> in_ready)
    else $error("input stalled with empty output");

endmodule

bind url_percent_decoder udec_checker u_chk (.*);
